// File: sv/least_common_multiple_top_defines.svh
`ifndef LEAST_COMMON_MULTIPLE_TOP_DEFINES_SVH
`define LEAST_COMMON_MULTIPLE_TOP_DEFINES_SVH

// Checks clocked on clk_i; LCM_ASSERT is masked during reset, LCM_ASSERT_RST is not.
`ifndef SYNTHESIS
`define LCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LCM_ASSERT(lbl, prop, msg)
`define LCM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: sv/lcm_pkg.sv
package lcm_pkg;

  localparam int DataW = 32;
  localparam int ValW  = DataW - 1;
  localparam int CntW  = $clog2(DataW);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2,
    ST_OVF  = 2'd3
  } lcm_status_e;

  typedef struct packed {
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } lcm_in_t;

  typedef struct packed {
    logic [ValW-1:0] multiple;
    lcm_status_e     status;
  } lcm_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lcm_stat_t;

endpackage

// File: sv/lcm_alu.sv
module lcm_alu (
  input  logic [lcm_pkg::DataW-1:0] x_i,
  input  logic [lcm_pkg::DataW-1:0] y_i,
  output logic [lcm_pkg::DataW-1:0] diff_o,
  output logic                      borrow_o
);
  import lcm_pkg::*;

  logic [DataW:0] full;

  assign full     = {1'b0, x_i} - {1'b0, y_i};
  assign diff_o   = full[DataW-1:0];
  assign borrow_o = full[DataW];

endmodule

// File: sv/lcm_core.sv
module lcm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lcm_pkg::lcm_in_t   op_i,
  input  logic               out_free_i,
  output lcm_pkg::lcm_stat_t stat_o,
  output lcm_pkg::lcm_out_t  res_o
);
  import lcm_pkg::*;

  typedef enum logic [3:0] {
    IDLE, STRIP, ODDU, GCD, SCALE, DIV, MUL, CHECK, FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [ValW-1:0]   a_q, a_d, b_q, b_d, u_q, u_d, v_q, v_d;
  logic [ValW-1:0]   quo_q, quo_d, rem_q, rem_d;
  logic [CntW-1:0]   k_q, k_d, cnt_q, cnt_d;
  logic [2*ValW-1:0] prod_q, prod_d;
  lcm_out_t          res_q, res_d;

  logic [DataW-1:0]  alu_x, alu_y, alu_diff;
  logic              alu_borrow;

  lcm_alu u_alu (
    .x_i     (alu_x),
    .y_i     (alu_y),
    .diff_o  (alu_diff),
    .borrow_o(alu_borrow)
  );

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    u_d     = u_q;
    v_d     = v_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    res_d   = res_q;
    alu_x   = {1'b0, v_q};
    alu_y   = {1'b0, u_q};

    case (state_q)
      IDLE: begin
        if (start_i) begin
          a_d = op_i.operand_a[ValW-1:0];
          b_d = op_i.operand_b[ValW-1:0];
          u_d = op_i.operand_a[ValW-1:0];
          v_d = op_i.operand_b[ValW-1:0];
          k_d = '0;
          res_d.multiple = '0;
          if (op_i.operand_a == '0 || op_i.operand_b == '0) begin
            res_d.status = ST_ZERO;
            state_d      = FINISH;
          end else if (op_i.operand_a[DataW-1] || op_i.operand_b[DataW-1]) begin
            res_d.status = ST_NEG;
            state_d      = FINISH;
          end else begin
            state_d = STRIP;
          end
        end
      end
      STRIP: begin
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = ODDU;
        end
      end
      ODDU: begin
        if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else begin
          state_d = GCD;
        end
      end
      GCD: begin
        // u stays odd; v is reduced until it reaches zero
        if (v_q == '0) begin
          state_d = SCALE;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (alu_borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          v_d = alu_diff[ValW-1:0];
        end
      end
      SCALE: begin
        if (k_q == '0) begin
          rem_d   = '0;
          quo_d   = a_q;
          cnt_d   = '0;
          state_d = DIV;
        end else begin
          u_d = u_q << 1;
          k_d = k_q - 1'b1;
        end
      end
      DIV: begin
        alu_x = {rem_q, quo_q[ValW-1]};
        alu_y = {1'b0, u_q};
        rem_d = alu_borrow ? alu_x[ValW-1:0] : alu_diff[ValW-1:0];
        quo_d = {quo_q[ValW-2:0], ~alu_borrow};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ValW - 1)) begin
          state_d = MUL;
        end
      end
      MUL: begin
        prod_d  = {{ValW{1'b0}}, quo_q} * {{ValW{1'b0}}, b_q};
        state_d = CHECK;
      end
      CHECK: begin
        if (prod_q[2*ValW-1:ValW] != '0) begin
          res_d.multiple = '0;
          res_d.status   = ST_OVF;
        end else begin
          res_d.multiple = prod_q[ValW-1:0];
          res_d.status   = ST_OK;
        end
        state_d = FINISH;
      end
      FINISH: begin
        if (out_free_i) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      a_q     <= '0;
      b_q     <= '0;
      u_q     <= '0;
      v_q     <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      prod_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      u_q     <= u_d;
      v_q     <= v_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      prod_q  <= prod_d;
      res_q   <= res_d;
    end
  end

  assign stat_o.busy = (state_q != IDLE);
  assign stat_o.done = (state_q == FINISH) && out_free_i;
  assign res_o       = res_q;

endmodule

// File: sv/least_common_multiple_top.sv
// channel | dir | handshake             | payload
// in      | in  | in_valid_i, in_stall_o | in_data_i  (operand_a, operand_b)
// out     | out | out_valid_o, out_stall_i | out_data_o (multiple, status)
// Zero or negative operands go straight to the finish state. Otherwise an item
// runs a common-twos strip, a binary GCD loop on the shared subtractor, a rescale,
// 31 restoring divide steps, a multiply and an overflow check.
// in_stall_o is high from acceptance until the result moves to the output register.
// The output register holds one beat; a stalled result blocks only the next finish.
// Asynchronous active-low reset returns to idle with no result pending.
`include "least_common_multiple_top_defines.svh"

module least_common_multiple_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lcm_pkg::lcm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lcm_pkg::lcm_out_t out_data_o
);
  import lcm_pkg::*;

  lcm_stat_t core_stat;
  lcm_out_t  core_res;
  logic      out_valid_q, out_valid_d;
  lcm_out_t  out_data_q;
  logic      out_free;
  logic      start;
  logic      err_beat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = core_stat.busy;
  assign start      = in_valid_i && !core_stat.busy;

  lcm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .op_i      (in_data_i),
    .out_free_i(out_free),
    .stat_o    (core_stat),
    .res_o     (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_stat.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_stat.done) begin
      out_data_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign err_beat    = out_valid_o && (out_data_o.status != ST_OK);

  `LCM_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")
  `LCM_ASSERT(a_done_needs_slot, core_stat.done |-> (!out_valid_q || !out_stall_i), "result overwritten")
  `LCM_ASSERT(a_error_zero, err_beat |-> (out_data_o.multiple == '0), "nonzero multiple on error")
  `LCM_ASSERT(a_reset_empty, !$past(rst_ni) |-> !out_valid_o, "output valid after reset")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lcm_pkg::*;

  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [31:0] NegMin = 32'h8000_0000;
  localparam int          Calm   = 40;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  lcm_in_t  in_data = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  lcm_out_t out_data_o;

  lcm_in_t  operand_pairs_q[$];
  lcm_out_t multiples_due_q[$];
  int       pair_total = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       in_gap, in_mode, out_left, out_mode;
  logic     nxt_valid, nxt_stall;
  lcm_in_t  nxt_data;
  lcm_out_t due;

  least_common_multiple_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic lcm_out_t lcm_of(lcm_in_t pair);
    logic [63:0] a, b, x, y, r, q;
    lcm_out_t res;
    a = {32'd0, pair.operand_a};
    b = {32'd0, pair.operand_b};
    res.multiple = '0;
    if (a == 0 || b == 0) begin
      res.status = ST_ZERO;
    end else if (a[31] || b[31]) begin
      res.status = ST_NEG;
    end else begin
      x = a;
      y = b;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      q = a / x;
      if (q > {32'd0, PosMax} / b) begin
        res.status = ST_OVF;
      end else begin
        res.multiple = ValW'(q * b);
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_pos(int bits);
    return $urandom_range(1, (32'h1 << bits) - 1);
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b);
    lcm_in_t pair;
    pair.operand_a = a;
    pair.operand_b = b;
    operand_pairs_q.push_back(pair);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap = 0;
      in_mode = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        multiples_due_q.push_back(lcm_of(in_data));
      end
      if (!in_valid || !in_stall_o) begin
        nxt_valid = 1'b0;
        nxt_data = in_data;
        if ($urandom_range(0, 31) == 0) in_mode = $urandom_range(0, 3);
        if (in_gap > 0) begin
          in_gap--;
        end else if (operand_pairs_q.size() >= Calm &&
                     $urandom_range(0, 15) < (in_mode == 3 ? 8 : in_mode == 2 ? 4 : in_mode)) begin
          in_gap = $urandom_range(0, 18);
        end else if (operand_pairs_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data = operand_pairs_q.pop_front();
        end
        in_valid <= nxt_valid;
        in_data <= nxt_data;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_left = 0;
      out_mode = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (multiples_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat multiple %0d status %0d", $realtime,
                     out_data_o.multiple, out_data_o.status);
        end else begin
          due = multiples_due_q.pop_front();
          if (out_data_o.multiple !== due.multiple || out_data_o.status !== due.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: multiple exp %0d got %0d, status exp %0d got %0d", $realtime,
                       due.multiple, out_data_o.multiple, due.status, out_data_o.status);
          end
        end
      end
      nxt_stall = 1'b0;
      if ($urandom_range(0, 199) == 0) out_mode = $urandom_range(0, 3);
      if (out_left > 0) begin
        out_left--;
        nxt_stall = 1'b1;
      end else if (results_seen < pair_total - Calm &&
                   $urandom_range(0, 15) < (out_mode == 3 ? 8 : out_mode == 2 ? 4 : out_mode)) begin
        out_left = $urandom_range(0, 18);
        nxt_stall = 1'b1;
      end
      out_stall <= nxt_stall;
    end
  end

  initial begin
    logic [31:0] a, b, g;
    logic [63:0] wide;
    int pick;

    add_pair(32'd1, 32'd1);
    add_pair(32'd0, 32'd5);
    add_pair(32'd5, 32'd0);
    add_pair(32'd0, 32'd0);
    add_pair(32'd0, 32'hFFFF_FFFD);
    add_pair(NegMin, 32'd0);
    add_pair(32'hFFFF_FFFF, 32'd5);
    add_pair(32'd5, 32'hFFFF_FFFF);
    add_pair(NegMin, NegMin);
    add_pair(NegMin, PosMax);
    add_pair(PosMax, PosMax);
    add_pair(PosMax, 32'd1);
    add_pair(32'd1, PosMax);
    add_pair(PosMax, PosMax - 1);
    add_pair(32'h4000_0000, 32'h4000_0000);
    add_pair(32'h4000_0000, 32'd2);
    add_pair(32'h4000_0000, 32'd3);
    add_pair(32'd6, 32'd4);
    add_pair(32'd12, 32'd18);
    add_pair(32'd17, 32'd19);
    add_pair(32'd65536, 32'd65537);
    add_pair(32'd46341, 32'd46340);
    add_pair(32'd46341, 32'd46341);
    add_pair(32'd1024, 32'd4096);

    repeat (476) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // common factor with random cofactors
        g = rand_pos($urandom_range(1, 14));
        a = rand_pos($urandom_range(1, 18));
        b = rand_pos($urandom_range(1, 18));
        wide = g * a;
        if (wide <= PosMax) a = wide[31:0];
        wide = g * b;
        if (wide <= PosMax) b = wide[31:0];
      end else if (pick < 60) begin
        a = rand_pos($urandom_range(1, 31));
        b = rand_pos($urandom_range(1, 31));
      end else if (pick < 70) begin
        a = rand_pos($urandom_range(1, 31));
        b = ($urandom_range(0, 3) == 0) ? a : rand_pos($urandom_range(1, 4));
      end else if (pick < 78) begin
        a = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
        b = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
        if (a != 0 && b != 0) a = 32'd0;
      end else if (pick < 90) begin
        a = $urandom() | NegMin;
        b = $urandom();
        if ($urandom_range(0, 1) == 0) begin
          g = a;
          a = b;
          b = g;
        end
      end else begin
        a = $urandom();
        b = $urandom();
      end
      add_pair(a, b);
    end
    pair_total = operand_pairs_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (operand_pairs_q.size() != 0 || in_valid || multiples_due_q.size() != 0);
    repeat (300) @(negedge clk_i);

    if (mismatches == 0 && multiples_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
